>>> hdl/gcv_pkg.sv
// Package with beat types, register indexes, gas law table and constant helpers.
package gcv_pkg;

    // Input sample width and derived widths.
    localparam int SAMPLE_BITS = 16;
    localparam int VOLT_W      = 15;
    localparam int CLEAN_W     = 24;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CLAMP_W     = (SAMPLE_BITS > VOLT_W ? SAMPLE_BITS : VOLT_W) + 1;
    localparam int NUM_W       = 45;
    localparam int DEN_W       = 39;
    localparam int Q_W         = 23;
    localparam int DIV_STAGES  = Q_W;
    localparam int CONC_W      = 25;

    // 47 kilo-ohm load with 8 fraction bits.
    localparam logic [13:0] LOAD_SCALE = 14'd12032;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLTAGE_MAX,
        REG_VOLTAGE_MIN,
        REG_REDUCING_CLEAN_AIR,
        REG_OXIDISING_CLEAN_AIR,
        REG_AMMONIA_CLEAN_AIR
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_OK,
        ST_RATIO,
        ST_CONC
    } t_status;

    typedef enum logic [1:0] {
        CH_REDUCING,
        CH_OXIDISING,
        CH_AMMONIA
    } t_channel;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_voltage;
        logic [2:0]                    func;
    } t_in_beat;

    typedef struct packed {
        logic [CONC_W-1:0] concentration;
        logic [1:0]        status;
    } t_out_beat;

    // Control that travels with each item through the pipeline.
    typedef struct packed {
        logic [2:0] func;
        logic       rej;
    } t_tag;

    typedef struct packed {
        t_channel            channel;
        logic [Q_W-1:0]      ratio_lo;
        logic [Q_W-1:0]      ratio_hi;
        logic signed [19:0]  expo;
        logic [25:0]         coef;
        logic [CONC_W-1:0]   conc_lo;
        logic [CONC_W-1:0]   conc_hi;
    } t_gas;

    // Power law and windows of each gas, all Q.16 except the Q.10 ppm windows.
    function automatic t_gas gas_law(input logic [2:0] func);
        t_gas g;
        unique case (func)
            3'd0: g = '{CH_REDUCING,  23'd655,   23'd262144,  -20'sd77136,
                        26'd292540,   25'd1024,    25'd1024000};
            3'd1: g = '{CH_OXIDISING, 23'd3932,  23'd2621440,  20'sd65398,
                        26'd9935,     25'd10,      25'd7168};
            3'd2: g = '{CH_AMMONIA,   23'd3277,  23'd58982,   -20'sd124715,
                        26'd40311,    25'd1024,    25'd163840};
            3'd3: g = '{CH_AMMONIA,   23'd13107, 23'd58982,   -20'sd163316,
                        26'd37326684, 25'd1024000, 25'd30720000};
            3'd4: g = '{CH_AMMONIA,   23'd6554,  23'd52429,   -20'sd123732,
                        26'd32977715, 25'd1024000, 25'd30720000};
            3'd5: g = '{CH_REDUCING,  23'd29491, 23'd52429,   -20'sd268239,
                        26'd54878536, 25'd3072000, 25'd10752000};
            3'd6: g = '{CH_REDUCING,  23'd2294,  23'd65536,   -20'sd116720,
                        26'd54264,    25'd1024,    25'd256000};
            default: g = '{CH_REDUCING, 23'd1966, 23'd68813,  -20'sd103547,
                        26'd89326,    25'd1536,    25'd256000};
        endcase
        return g;
    endfunction

    // Floored integer square root, evaluated at elaboration only.
    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = n;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) in Q.30, each root taken from the previous floored one.
    function automatic logic [30:0] exp2_root(input int k);
        logic [63:0] c;
        c = 64'd2 << 30;
        for (int i = 1; i <= 16; i++) begin
            if (i <= k) begin
                c = int_sqrt(c << 30);
            end
        end
        return c[30:0];
    endfunction

endpackage

>>> hdl/gas_concentration_from_voltage.sv
// Top level: pipelined gas concentration from a sensor divider voltage.
//
// Each beat carries one signed converter sample and a gas selector and yields one
// result beat of concentration (ppm, 10 fraction bits) and status. The block takes
// one sample per clock when the output side keeps up. Its pipeline holds the 23-stage
// divider that forms the resistance ratio, the 16 squaring stages of log2 and the 16
// multiply stages of exp2. Stages advance independently, so bubbles close up while
// the output waits and input is refused only when every stage holds an item.
// Configuration is written through a plain write port and must be changed only while
// no item is in flight.
module gas_concentration_from_voltage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  gcv_pkg::t_in_beat             i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output gcv_pkg::t_out_beat            o_data,
    input  logic                          i_cfg_wr_en,
    input  logic [gcv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gcv_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import gcv_pkg::*;

    localparam int LOG_STAGES = 16;
    localparam int EXP_STAGES = 16;
    localparam int ST_A   = 0;
    localparam int ST_B   = 1;
    localparam int ST_DIV = 2;
    localparam int ST_C   = ST_DIV + DIV_STAGES;
    localparam int ST_LOG = ST_C + 1;
    localparam int ST_M   = ST_LOG + LOG_STAGES;
    localparam int ST_N   = ST_M + 1;
    localparam int ST_EXP = ST_N + 1;
    localparam int ST_P   = ST_EXP + EXP_STAGES;
    localparam int ST_Q   = ST_P + 1;
    localparam int ST_R   = ST_Q + 1;
    localparam int NS     = ST_R + 1;

    // Configuration registers.
    logic [VOLT_W-1:0]  r_vmax;
    logic [VOLT_W-1:0]  r_vmin;
    logic [CLEAN_W-1:0] r_clean_red;
    logic [CLEAN_W-1:0] r_clean_oxi;
    logic [CLEAN_W-1:0] r_clean_nh3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vmax      <= 15'd32767;
            r_vmin      <= '0;
            r_clean_red <= 24'd256;
            r_clean_oxi <= 24'd256;
            r_clean_nh3 <= 24'd256;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_VOLTAGE_MAX:         r_vmax      <= i_cfg_wdata[VOLT_W-1:0];
                REG_VOLTAGE_MIN:         r_vmin      <= i_cfg_wdata[VOLT_W-1:0];
                REG_REDUCING_CLEAN_AIR:  r_clean_red <= i_cfg_wdata;
                REG_OXIDISING_CLEAN_AIR: r_clean_oxi <= i_cfg_wdata;
                REG_AMMONIA_CLEAN_AIR:   r_clean_nh3 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage valid bits and per-stage load enables; a stage loads when it is empty
    // or its content moves on.
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    assign en[NS-1] = !r_v[NS-1] || i_ready;
    genvar k;
    generate
        for (k = 0; k < NS - 1; k++) begin : g_en
            assign en[k] = !r_v[k] || en[k+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];

    // Stage A: input register.
    t_in_beat r_a_in;
    always_ff @(posedge i_clk) begin
        if (en[ST_A]) begin
            r_a_in <= i_data;
        end
    end

    // Stage B: clamp, channel select, divider operands.
    logic signed [CLAMP_W-1:0] b_s;
    logic signed [CLAMP_W-1:0] b_vmax;
    logic signed [CLAMP_W-1:0] b_vmin;
    logic signed [CLAMP_W-1:0] b_v1;
    logic signed [CLAMP_W-1:0] b_v2;
    logic [VOLT_W-1:0]         b_v;
    logic [VOLT_W-1:0]         b_diff;
    logic [CLEAN_W-1:0]        b_clean;
    logic [28:0]               b_scaled;
    t_gas                      b_gas;
    logic [NUM_W-1:0]          r_b_num;
    logic [DEN_W-1:0]          r_b_den;
    t_tag                      r_b_tag;

    always_comb begin
        b_s    = CLAMP_W'(r_a_in.sample_voltage);
        b_vmax = signed'(CLAMP_W'(r_vmax));
        b_vmin = signed'(CLAMP_W'(r_vmin));
        b_v1   = (b_s > b_vmax) ? b_vmax : b_s;
        b_v2   = (b_v1 < b_vmin) ? b_vmin : b_v1;
        b_v    = b_v2[VOLT_W-1:0];
        b_diff = r_vmax - b_v;
        b_gas  = gas_law(r_a_in.func);
        case (b_gas.channel)
            CH_REDUCING:  b_clean = r_clean_red;
            CH_OXIDISING: b_clean = r_clean_oxi;
            default:      b_clean = r_clean_nh3;
        endcase
        b_scaled = 29'(b_v) * 29'(LOAD_SCALE);
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_B]) begin
            r_b_num      <= {b_scaled, 16'd0};
            r_b_den      <= DEN_W'(b_diff) * DEN_W'(b_clean);
            r_b_tag.func <= r_a_in.func;
            r_b_tag.rej  <= (b_v >= r_vmax) || (b_clean == '0);
        end
    end

    // Divider stages: resistance ratio in Q.16.
    logic [Q_W-1:0] div_q;
    t_tag           div_tag;

    gcv_div u_div (
        .i_clk (i_clk),
        .i_en  (en[ST_DIV +: DIV_STAGES]),
        .i_num (r_b_num),
        .i_den (r_b_den),
        .i_tag (r_b_tag),
        .o_q   (div_q),
        .o_tag (div_tag)
    );

    // Stage C: ratio window and normalization of the mantissa.
    t_gas        c_gas;
    logic [4:0]  c_p;
    logic [30:0] r_c_x;
    logic [4:0]  r_c_p;
    t_tag        r_c_tag;

    always_comb begin
        c_gas = gas_law(div_tag.func);
        c_p   = '0;
        for (int i = 0; i < Q_W; i++) begin
            if (div_q[i]) begin
                c_p = 5'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_C]) begin
            r_c_x        <= 31'(div_q) << (5'd30 - c_p);
            r_c_p        <= c_p;
            r_c_tag.func <= div_tag.func;
            r_c_tag.rej  <= div_tag.rej || (div_q < c_gas.ratio_lo)
                            || (div_q > c_gas.ratio_hi);
        end
    end

    // Log2 stages: one squaring of the mantissa per stage, one fraction bit each.
    logic [30:0] r_l_x    [LOG_STAGES];
    logic [15:0] r_l_frac [LOG_STAGES];
    logic [4:0]  r_l_p    [LOG_STAGES];
    t_tag        r_l_tag  [LOG_STAGES];

    generate
        for (k = 0; k < LOG_STAGES; k++) begin : g_log
            logic [30:0] x_in;
            logic [15:0] f_in;
            logic [4:0]  p_in;
            t_tag        tag_in;
            logic [61:0] sq;
            logic [31:0] t;

            if (k == 0) begin : g_first
                assign x_in   = r_c_x;
                assign f_in   = '0;
                assign p_in   = r_c_p;
                assign tag_in = r_c_tag;
            end else begin : g_next
                assign x_in   = r_l_x[k-1];
                assign f_in   = r_l_frac[k-1];
                assign p_in   = r_l_p[k-1];
                assign tag_in = r_l_tag[k-1];
            end

            assign sq = 62'(x_in) * 62'(x_in);
            assign t  = sq[61:30];

            always_ff @(posedge i_clk) begin
                if (en[ST_LOG + k]) begin
                    r_l_x[k]    <= t[31] ? t[31:1] : t[30:0];
                    r_l_frac[k] <= f_in | (16'(t[31]) << (LOG_STAGES - 1 - k));
                    r_l_p[k]    <= p_in;
                    r_l_tag[k]  <= tag_in;
                end
            end
        end
    endgenerate

    // Stage M: exponent times log2.
    t_gas                m_gas;
    logic signed [21:0]  m_lg;
    logic signed [41:0]  r_m_prod;
    t_tag                r_m_tag;

    always_comb begin
        m_gas = gas_law(r_l_tag[LOG_STAGES-1].func);
        m_lg  = signed'({6'({1'b0, r_l_p[LOG_STAGES-1]}) - 6'd16,
                         r_l_frac[LOG_STAGES-1]});
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_M]) begin
            r_m_prod <= 42'(m_gas.expo) * 42'(m_lg);
            r_m_tag  <= r_l_tag[LOG_STAGES-1];
        end
    end

    // Stage N: round to Q.16, split into integer shift and fraction.
    logic [41:0]         n_pm;
    logic [25:0]         n_mag;
    logic signed [28:0]  n_y;
    logic signed [28:0]  n_yb;
    logic signed [9:0]   r_n_sh;
    logic [15:0]         r_n_f;
    t_tag                r_n_tag;

    always_comb begin
        n_pm  = r_m_prod[41] ? 42'(-r_m_prod) : 42'(r_m_prod);
        n_mag = 26'((n_pm + 42'd32768) >> 16);
        n_y   = r_m_prod[41] ? -signed'(29'(n_mag)) : signed'(29'(n_mag));
        n_yb  = n_y + 29'sd4194304;
        if (n_yb < 0) begin
            n_yb = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_N]) begin
            // Final right shift is 36 - n with n = floor(yb) - 64.
            r_n_sh  <= 10'sd100 - signed'({2'b00, n_yb[23:16]});
            r_n_f   <= n_yb[15:0];
            r_n_tag <= r_m_tag;
        end
    end

    // Exp2 stages: multiply in one root of two per fraction bit.
    logic [30:0]        r_e_pw  [EXP_STAGES];
    logic [15:0]        r_e_f   [EXP_STAGES];
    logic signed [9:0]  r_e_sh  [EXP_STAGES];
    t_tag               r_e_tag [EXP_STAGES];

    generate
        for (k = 0; k < EXP_STAGES; k++) begin : g_exp
            localparam logic [30:0] ROOT = exp2_root(k + 1);
            logic [30:0]       pw_in;
            logic [15:0]       f_in;
            logic signed [9:0] sh_in;
            t_tag              tag_in;
            logic [61:0]       mul;

            if (k == 0) begin : g_first
                assign pw_in  = 31'd1 << 30;
                assign f_in   = r_n_f;
                assign sh_in  = r_n_sh;
                assign tag_in = r_n_tag;
            end else begin : g_next
                assign pw_in  = r_e_pw[k-1];
                assign f_in   = r_e_f[k-1];
                assign sh_in  = r_e_sh[k-1];
                assign tag_in = r_e_tag[k-1];
            end

            assign mul = 62'(pw_in) * 62'(ROOT);

            always_ff @(posedge i_clk) begin
                if (en[ST_EXP + k]) begin
                    r_e_pw[k]  <= f_in[EXP_STAGES-1-k] ? mul[60:30] : pw_in;
                    r_e_f[k]   <= f_in;
                    r_e_sh[k]  <= sh_in;
                    r_e_tag[k] <= tag_in;
                end
            end
        end
    endgenerate

    // Stage P: coefficient times power of two fraction.
    t_gas               p_gas;
    logic [56:0]        r_p_m;
    logic signed [9:0]  r_p_sh;
    t_tag               r_p_tag;

    assign p_gas = gas_law(r_e_tag[EXP_STAGES-1].func);

    always_ff @(posedge i_clk) begin
        if (en[ST_P]) begin
            r_p_m   <= 57'(p_gas.coef) * 57'(r_e_pw[EXP_STAGES-1]);
            r_p_sh  <= r_e_sh[EXP_STAGES-1];
            r_p_tag <= r_e_tag[EXP_STAGES-1];
        end
    end

    // Stage Q: rounding right shift with underflow and saturation.
    logic [5:0]        q_shu;
    logic [63:0]       q_conc;
    logic [CONC_W-1:0] r_q_conc;
    logic              r_q_ovf;
    t_tag              r_q_tag;

    always_comb begin
        q_shu = r_p_sh[5:0];
        if (r_p_sh >= 10'sd63) begin
            q_conc = '0;
        end else if (r_p_sh < 10'sd1) begin
            q_conc = '1;
        end else begin
            q_conc = (64'(r_p_m) + (64'd1 << (q_shu - 6'd1))) >> q_shu;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_Q]) begin
            r_q_conc <= q_conc[CONC_W-1:0];
            r_q_ovf  <= |q_conc[63:CONC_W];
            r_q_tag  <= r_p_tag;
        end
    end

    // Stage R: concentration window and output register.
    t_gas      r_gas;
    t_out_beat r_out;

    assign r_gas = gas_law(r_q_tag.func);

    always_ff @(posedge i_clk) begin
        if (en[ST_R]) begin
            if (r_q_tag.rej) begin
                r_out.concentration <= '0;
                r_out.status        <= ST_RATIO;
            end else if (r_q_ovf || (r_q_conc < r_gas.conc_lo)
                         || (r_q_conc > r_gas.conc_hi)) begin
                r_out.concentration <= '0;
                r_out.status        <= ST_CONC;
            end else begin
                r_out.concentration <= r_q_conc;
                r_out.status        <= ST_OK;
            end
        end
    end

    assign o_data = r_out;

    // Input is refused only when every stage holds an item.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_v))
        else $error("input stalled while the pipeline has a bubble");

    // A rejected result carries zero concentration.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.status != ST_OK)) |-> (o_data.concentration == '0))
        else $error("rejected result with nonzero concentration");

    // An accepted result lies inside a window, so it is never zero.
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.status == ST_OK)) |-> (o_data.concentration != '0))
        else $error("valid result with zero concentration");

endmodule

>>> hdl/gcv_div.sv
// Restoring divider pipeline, one quotient bit per stage, with overflow rejection.
module gcv_div (
    input  logic                        i_clk,
    input  logic [gcv_pkg::DIV_STAGES-1:0] i_en,
    input  logic [gcv_pkg::NUM_W-1:0]   i_num,
    input  logic [gcv_pkg::DEN_W-1:0]   i_den,
    input  gcv_pkg::t_tag               i_tag,
    output logic [gcv_pkg::Q_W-1:0]     o_q,
    output gcv_pkg::t_tag               o_tag
);
    import gcv_pkg::*;

    localparam int CMP_W = DEN_W + Q_W;

    logic [NUM_W-1:0] r_rem [DIV_STAGES];
    logic [DEN_W-1:0] r_den [DIV_STAGES];
    logic [Q_W-1:0]   r_q   [DIV_STAGES];
    t_tag             r_tag [DIV_STAGES];

    genvar j;
    generate
        for (j = 0; j < DIV_STAGES; j++) begin : g_stage
            localparam int B = Q_W - 1 - j;
            logic [NUM_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [Q_W-1:0]   q_in;
            t_tag             tag_in;
            logic [CMP_W-1:0] dsh;
            logic             ge;
            logic             ovf;

            if (j == 0) begin : g_first
                assign rem_in = i_num;
                assign den_in = i_den;
                assign q_in   = '0;
                assign tag_in = i_tag;
                // A quotient that needs more than Q_W bits is out of every window.
                assign ovf    = CMP_W'(i_num) >= (CMP_W'(i_den) << Q_W);
            end else begin : g_next
                assign rem_in = r_rem[j-1];
                assign den_in = r_den[j-1];
                assign q_in   = r_q[j-1];
                assign tag_in = r_tag[j-1];
                assign ovf    = 1'b0;
            end

            // Trial subtraction of the shifted divisor.
            assign dsh = CMP_W'(den_in) << B;
            assign ge  = CMP_W'(rem_in) >= dsh;

            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j] <= ge ? rem_in - dsh[NUM_W-1:0] : rem_in;
                    r_den[j] <= den_in;
                    r_q[j]   <= q_in | (Q_W'(ge) << B);
                    r_tag[j] <= '{func: tag_in.func, rej: tag_in.rej | ovf};
                end
            end
        end
    endgenerate

    assign o_q   = r_q[DIV_STAGES-1];
    assign o_tag = r_tag[DIV_STAGES-1];

endmodule
